// ===== src/cdzp_pkg.sv =====
// cdzp_pkg: shared types and constants of the coefficient deadzone and zero-run packer
// used by the lane, merge, group queue and top-level files; depends on nothing else
`default_nettype none
package cdzp_pkg;

    // block geometry
    localparam int LUMA_WORDS  = 16;
    localparam int WORD_POS_W  = 5;
    localparam int LANES       = 4;
    localparam int BYTE_W      = 8;
    localparam int LOSS_W      = 6;

    // word position within one 8x8 component, and the words holding positions 0, 1, 8 and 9
    localparam int              COMP_POS_W  = 4;
    localparam logic [COMP_POS_W-1:0] KEEP_WORD_LO = 4'd0;
    localparam logic [COMP_POS_W-1:0] KEEP_WORD_HI = 4'd2;
    localparam int              KEEP_LANES  = 2;

    // group format
    localparam int             RUN_W      = 6;
    localparam int             HELD_W     = 2;
    localparam int             MAX_LITS   = 3;
    localparam logic [HELD_W-1:0] HELD_FULL = 2'd3;
    localparam logic [RUN_W:0] RUN_LIMIT  = 7'd63;
    localparam logic [RUN_W-1:0] RUN_MAX  = 6'd62;
    localparam int             REM_W      = 3;

    // one group per lane plus the closing group of a block
    localparam int MAX_GROUPS = LANES + 1;
    localparam int GRP_CNT_W  = 3;

    // stream widths
    localparam int LOSS_LSB  = LANES * BYTE_W;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;
    localparam int CNT_LSB   = 4 * BYTE_W;

    typedef logic [BYTE_W-1:0] byte_t;

    // one word after the deadzone, with its place in the block
    typedef struct packed {
        logic                    first;
        logic                    last;
        byte_t [LANES-1:0]       coef;
    } word_t;

    // one finished group
    typedef struct packed {
        logic [BYTE_W-1:0]       header;
        byte_t [MAX_LITS-1:0]    lits;
        logic [HELD_W-1:0]       lit_count;
        logic                    block_end;
    } group_t;

    // write request from the merge stage to the group queue
    typedef struct packed {
        logic                    en;
        logic [GRP_CNT_W-1:0]    num;
    } grp_wr_t;

endpackage
`default_nettype wire

// ===== src/cdzp_lane.sv =====
// cdzp_lane: deadzone for one coefficient byte of a word
// uses cdzp_pkg; four copies sit side by side in the top level
`default_nettype none
module cdzp_lane
    import cdzp_pkg::*;
(
    input  wire  [BYTE_W-1:0] coef,
    input  wire  [LOSS_W:0]   thr,
    input  wire               keep,
    output logic [BYTE_W-1:0] coef_dz
);

    logic [BYTE_W:0] mag;
    logic            in_zone;

    // magnitude of the signed byte, 128 fits in nine bits
    assign mag = coef[BYTE_W-1] ? ((BYTE_W+1)'(0) - {1'b1, coef}) : {1'b0, coef};

    // inside the deadzone when |b| <= thr
    assign in_zone = mag <= {{(BYTE_W-LOSS_W){1'b0}}, thr};

    assign coef_dz = (!keep && in_zone) ? '0 : coef;

endmodule
`default_nettype wire

// ===== src/cdzp_merge.sv =====
// cdzp_merge: merging stage, walks the four lane bytes through the group packer
// uses cdzp_pkg; feeds up to five groups a word into cdzp_gfifo
`default_nettype none
module cdzp_merge
    import cdzp_pkg::*;
(
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          word_valid,
    input  wire  word_t                  word,
    input  wire                          room,
    output logic                         take,
    output grp_wr_t                      wr,
    output group_t [MAX_GROUPS-1:0]      groups
);

    typedef struct packed {
        logic                    zphase;
        logic [HELD_W-1:0]       held;
        logic [RUN_W-1:0]        run;
        byte_t [MAX_LITS-1:0]    lits;
    } pk_state_t;

    logic                     zphase_reg;
    logic [HELD_W-1:0]        held_reg;
    logic [RUN_W-1:0]         run_reg;
    byte_t [MAX_LITS-1:0]     lits_reg;
    pk_state_t                cur;
    pk_state_t                st_next;
    logic [MAX_GROUPS-1:0]    emit_vec;
    group_t [MAX_GROUPS-1:0]  slot_grp;
    logic [GRP_CNT_W-1:0]     grp_num;

    function automatic group_t make_group(input pk_state_t s, input logic fin);
        group_t g;
        g.header    = {s.held, s.run};
        for (int i = 0; i < MAX_LITS; i++) begin
            g.lits[i] = (HELD_W'(i) < s.held) ? s.lits[i] : '0;
        end
        g.lit_count = s.held;
        g.block_end = fin;
        return g;
    endfunction

    assign cur = '{zphase: zphase_reg, held: held_reg, run: run_reg, lits: lits_reg};

    // byte chain: each lane byte may close the open group before it is taken
    always_comb begin
        byte_t           b;
        logic [REM_W-1:0] rem;
        st_next  = cur;
        emit_vec = '0;
        slot_grp = '0;
        b        = '0;
        rem      = '0;
        // first byte of a block always opens the first group as a literal
        if (word.first) begin
            st_next.zphase  = 1'b0;
            st_next.held    = HELD_W'(1);
            st_next.run     = '0;
            st_next.lits[0] = word.coef[0];
        end
        for (int k = 0; k < LANES; k++) begin
            if (!(word.first && k == 0)) begin
                b   = word.coef[k];
                rem = REM_W'(LANES - k);
                // zero run would overflow, or a literal follows the zeros
                if (st_next.zphase &&
                    ((({1'b0, st_next.run} + {{(RUN_W+1-REM_W){1'b0}}, rem}) >= RUN_LIMIT) ||
                     (b != '0))) begin
                    emit_vec[k]    = 1'b1;
                    slot_grp[k]    = make_group(st_next, 1'b0);
                    st_next.zphase = 1'b0;
                    st_next.held   = '0;
                    st_next.run    = '0;
                end
                if (!st_next.zphase) begin
                    if (b != '0) begin
                        st_next.lits[st_next.held] = b;
                        st_next.held = st_next.held + HELD_W'(1);
                        if (st_next.held == HELD_FULL) begin
                            st_next.zphase = 1'b1;
                        end
                    end else begin
                        st_next.zphase = 1'b1;
                        st_next.run    = st_next.run + RUN_W'(1);
                    end
                end else begin
                    st_next.run = st_next.run + RUN_W'(1);
                end
            end
        end
        // last word closes the open group, possibly empty
        if (word.last) begin
            emit_vec[LANES] = 1'b1;
            slot_grp[LANES] = make_group(st_next, 1'b1);
            st_next.zphase  = 1'b0;
            st_next.held    = '0;
            st_next.run     = '0;
        end
    end

    // pack the emitted slots down to consecutive queue entries
    always_comb begin
        logic [GRP_CNT_W-1:0] idx;
        idx    = '0;
        groups = '0;
        for (int s = 0; s < MAX_GROUPS; s++) begin
            if (emit_vec[s]) begin
                groups[idx] = slot_grp[s];
                idx         = idx + GRP_CNT_W'(1);
            end
        end
        grp_num = idx;
    end

    assign take   = word_valid && room;
    assign wr.en  = take;
    assign wr.num = grp_num;

    // packer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zphase_reg <= 1'b0;
            held_reg   <= '0;
            run_reg    <= '0;
        end else if (take) begin
            zphase_reg <= st_next.zphase;
            held_reg   <= st_next.held;
            run_reg    <= st_next.run;
        end
    end

    // literal bytes, masked by the held count on the way out
    always_ff @(posedge aclk) begin
        if (take) begin
            lits_reg <= st_next.lits;
        end
    end

    // a full literal set always moves on to the zero phase
    a_full_lits_zphase: assert property (@(posedge aclk) disable iff (!aresetn)
        !zphase_reg |-> (held_reg != HELD_FULL))
        else $error("literal phase holding a full literal set");

    // zeros are only counted in the zero phase
    a_run_only_zphase: assert property (@(posedge aclk) disable iff (!aresetn)
        (run_reg != '0) |-> zphase_reg)
        else $error("zero run outside the zero phase");

    // the run is cut before it reaches the limit
    a_run_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        take |=> (run_reg <= RUN_MAX))
        else $error("zero run beyond its limit");

endmodule
`default_nettype wire

// ===== src/cdzp_gfifo.sv =====
// cdzp_gfifo: group queue, takes up to five groups a cycle and hands out one
// uses cdzp_pkg; sits between cdzp_merge and the result channel
`default_nettype none
module cdzp_gfifo
    import cdzp_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  grp_wr_t                wr,
    input  wire  group_t [MAX_GROUPS-1:0] wr_grp,
    output logic                         room,
    output logic                         rd_valid,
    input  wire                          rd_ready,
    output group_t                       rd_grp
);

    localparam int PTR_W = $clog2(DEPTH);

    group_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic [PTR_W:0]     count_next;
    logic [PTR_W:0]     free;
    logic               rd_fire;

    // space check against the groups of the waiting word
    assign free = (PTR_W+1)'(DEPTH) - count_reg;
    assign room = free >= (PTR_W+1)'(wr.num);

    assign rd_valid = count_reg != '0;
    assign rd_grp   = mem_reg[rd_ptr_reg];
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (wr.en) begin
            count_next = count_next + (PTR_W+1)'(wr.num);
        end
        if (rd_fire) begin
            count_next = count_next - (PTR_W+1)'(1);
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (wr.en) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(wr.num);
            end
            if (rd_fire) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // group storage, written at consecutive entries
    always_ff @(posedge aclk) begin
        for (int j = 0; j < MAX_GROUPS; j++) begin
            if (wr.en && (GRP_CNT_W'(j) < wr.num)) begin
                mem_reg[wr_ptr_reg + PTR_W'(j)] <= wr_grp[j];
            end
        end
    end

    // writes never run past the free space
    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        wr.en |-> room)
        else $error("group queue written beyond its free space");

    // the fill level follows the groups written
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr.en && !rd_fire) |=> (count_reg == $past(count_reg) + (PTR_W+1)'($past(wr.num))))
        else $error("group queue level lost track of writes");

endmodule
`default_nettype wire

// ===== src/coef_deadzone_zero_run_packer.sv =====
// coef_deadzone_zero_run_packer: top level, deadzone lanes, word register, merge and queue
// uses cdzp_pkg, cdzp_lane, cdzp_merge and cdzp_gfifo
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  coefficient word and loss
// m_axis    out        m_axis_tvalid/m_axis_tready  one group, tlast on the block's last
// cfg       in         cfg_wr_en                    colour enable
//
// an item is taken every cycle while the group queue has room for its groups
// a group reaches m_axis through the word register and then the group queue
// groups leave at one a cycle while m_axis_tready is high; new items are taken meanwhile
// synchronous active-low reset clears the word count, packer state and queue
// m_axis stalls back up through the queue into the word register, then s_axis_tready
`default_nettype none
module coef_deadzone_zero_run_packer
    import cdzp_pkg::*;
#(
    parameter int GROUP_QUEUE_DEPTH = 8
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  cfg_wr_en,
    input  wire                  cfg_wr_data,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // coef_a, coef_b, coef_c, coef_d, loss, two zero bits
    input  wire  [S_TDATA_W-1:0] s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // header, lit_first, lit_second, lit_third, lit_count, six zero bits
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic                 m_axis_tlast
);

    localparam logic [WORD_POS_W-1:0] LUMA_LAST  = WORD_POS_W'(LUMA_WORDS - 1);
    localparam logic [WORD_POS_W-1:0] BLOCK_LAST = WORD_POS_W'(2 * LUMA_WORDS - 1);
    localparam logic [WORD_POS_W-1:0] CHROMA_POS = WORD_POS_W'(LUMA_WORDS);

    logic                     color_en_reg;
    logic [WORD_POS_W-1:0]    word_pos_reg;
    logic [WORD_POS_W-1:0]    word_pos_next;
    logic                     a_valid_reg;
    logic                     a_valid_next;
    word_t                    a_word_reg;
    word_t                    word_in;
    logic                     s_fire;
    logic                     in_last;
    logic [LOSS_W-1:0]        loss;
    logic [LOSS_W:0]          thr;
    logic                     keep_word;
    byte_t [LANES-1:0]        lane_dz;
    logic                     take;
    grp_wr_t                  grp_wr;
    group_t [MAX_GROUPS-1:0]  grp_list;
    logic                     room;
    group_t                   out_grp;

    // colour enable register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_en_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            color_en_reg <= cfg_wr_data;
        end
    end

    // word position, advanced per accepted item
    assign s_fire  = s_axis_tvalid && s_axis_tready;
    assign in_last = word_pos_reg >= (color_en_reg ? BLOCK_LAST : LUMA_LAST);
    assign word_pos_next = in_last ? '0 : word_pos_reg + WORD_POS_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_pos_reg <= '0;
        end else if (s_fire) begin
            word_pos_reg <= word_pos_next;
        end
    end

    // deadzone width and the kept positions of this word
    assign loss      = s_axis_tdata[LOSS_LSB +: LOSS_W];
    assign thr       = (word_pos_reg >= CHROMA_POS) ? {loss, 1'b0} : {1'b0, loss};
    assign keep_word = (word_pos_reg[COMP_POS_W-1:0] == KEEP_WORD_LO) ||
                       (word_pos_reg[COMP_POS_W-1:0] == KEEP_WORD_HI);

    // one deadzone lane per byte
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        cdzp_lane u_lane (
            .coef    (s_axis_tdata[k*BYTE_W +: BYTE_W]),
            .thr     (thr),
            .keep    (keep_word & (k < KEEP_LANES)),
            .coef_dz (lane_dz[k])
        );
    end

    assign word_in.first = word_pos_reg == '0;
    assign word_in.last  = in_last;
    assign word_in.coef  = lane_dz;

    // word register between the lanes and the merge stage
    assign s_axis_tready = !a_valid_reg || take;
    assign a_valid_next  = s_fire ? 1'b1 : (take ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            a_word_reg <= word_in;
        end
    end

    cdzp_merge u_merge (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .word_valid (a_valid_reg),
        .word       (a_word_reg),
        .room       (room),
        .take       (take),
        .wr         (grp_wr),
        .groups     (grp_list)
    );

    cdzp_gfifo #(
        .DEPTH (GROUP_QUEUE_DEPTH)
    ) u_gfifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (grp_wr),
        .wr_grp   (grp_list),
        .room     (room),
        .rd_valid (m_axis_tvalid),
        .rd_ready (m_axis_tready),
        .rd_grp   (out_grp)
    );

    // result packing
    assign m_axis_tdata = {{(M_TDATA_W-CNT_LSB-HELD_W){1'b0}},
                           out_grp.lit_count,
                           out_grp.lits[2],
                           out_grp.lits[1],
                           out_grp.lits[0],
                           out_grp.header};
    assign m_axis_tlast = out_grp.block_end;

    // the item closing a block restarts the word count
    a_block_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && in_last) |=> (word_pos_reg == '0))
        else $error("word position did not return to zero after the last item");

endmodule
`default_nettype wire
